@@ hw/rtl/sparse_one_hot_scatter_core_assert.svh @@
// Assertion macros for the checker file of the scatter core.
`ifndef SPARSE_ONE_HOT_SCATTER_CORE_ASSERT_SVH
`define SPARSE_ONE_HOT_SCATTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, quiet during reset.
`define SOSC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sosc: same-cycle check failed");

// Next-cycle implication, sampled on the rising edge, quiet during reset.
`define SOSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sosc: next-cycle check failed");

`endif

@@ hw/rtl/sosc_pkg.sv @@
package sosc_pkg;

  localparam int LEVEL_CODE_W = 7;
  localparam int LEVEL_IDX_W  = 6;
  localparam int SLOT_W       = 20;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 7;

  localparam logic [SLOT_W-1:0] SLOT_MAX = {SLOT_W{1'b1}};

  localparam int DEF_MAX_LEVELS = 64;
  localparam int DEF_MAX_LENGTH = 1048576;

  localparam logic [LEVEL_CODE_W-1:0] RST_LEVEL_COUNT    = 7'd2;
  localparam logic                    RST_ONE_HOT_MODE   = 1'b1;
  localparam logic                    RST_MISSING_ENABLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_COUNT    = 2'd0,
    CFG_ONE_HOT_MODE   = 2'd1,
    CFG_MISSING_ENABLE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [LEVEL_CODE_W-1:0] level_count;
    logic                    one_hot_mode;
    logic                    missing_enable;
  } cfg_t;

endpackage

@@ hw/rtl/sosc_cfg_regs.sv @@
module sosc_cfg_regs
  import sosc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_LEVEL_COUNT:    cfg_nxt.level_count    = cfg_data;
        CFG_ONE_HOT_MODE:   cfg_nxt.one_hot_mode   = cfg_data[0];
        CFG_MISSING_ENABLE: cfg_nxt.missing_enable = cfg_data[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_count    <= RST_LEVEL_COUNT;
      cfg_r.one_hot_mode   <= RST_ONE_HOT_MODE;
      cfg_r.missing_enable <= RST_MISSING_ENABLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/sosc_slot_ram.sv @@
module sosc_slot_ram
  import sosc_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_LEVELS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [SLOT_W-1:0] rdata,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [SLOT_W-1:0] wdata
);

  logic [SLOT_W-1:0] mem [DEPTH];
  logic [SLOT_W-1:0] rdata_r;

  assign rdata = rdata_r;

  // Read data holds while no read is issued, so a stalled consumer keeps it.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/sosc_engine.sv @@
module sosc_engine
  import sosc_pkg::*;
#(
  parameter int MAX_LEVELS = DEF_MAX_LEVELS,
  parameter int MAX_LENGTH = DEF_MAX_LENGTH,
  parameter int POS_W      = $clog2(MAX_LENGTH + 1),
  parameter int LVL_W      = $clog2(MAX_LEVELS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [LEVEL_CODE_W-1:0] in_level_code,
  input  logic                    in_is_missing,
  input  logic                    in_last_element,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LEVEL_IDX_W-1:0]  out_level_index,
  output logic [SLOT_W-1:0]       out_slot_index,
  output logic [POS_W-1:0]        out_position,
  output logic                    out_value_missing,
  output logic                    out_error_flag,
  output logic                    out_last_of_run,
  output logic                    mem_re,
  output logic [LVL_W-1:0]        mem_raddr,
  input  logic [SLOT_W-1:0]       mem_rdata,
  output logic                    mem_we,
  output logic [LVL_W-1:0]        mem_waddr,
  output logic [SLOT_W-1:0]       mem_wdata
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  typedef enum logic [1:0] {
    K_ENTRY = 2'd0,
    K_WALK  = 2'd1,
    K_ERROR = 2'd2,
    K_NONE  = 2'd3
  } kind_t;

  localparam logic [LEVEL_CODE_W-1:0] MAX_LVL_C = LEVEL_CODE_W'(MAX_LEVELS);
  localparam logic [POS_W-1:0]        MAX_POS_C = POS_W'(MAX_LENGTH);

  state_t                  state_r, state_nxt;
  kind_t                   kind_r, kind_nxt;
  logic [LVL_W-1:0]        lvl_r, lvl_nxt;
  logic                    last_r, last_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [MAX_LEVELS-1:0]   valid_r, valid_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [LEVEL_IDX_W-1:0]  out_level_index_r, out_level_index_nxt;
  logic [SLOT_W-1:0]       out_slot_index_r, out_slot_index_nxt;
  logic [POS_W-1:0]        out_position_r, out_position_nxt;
  logic                    out_value_missing_r, out_value_missing_nxt;
  logic                    out_error_flag_r, out_error_flag_nxt;
  logic                    out_last_of_run_r, out_last_of_run_nxt;

  logic [LEVEL_CODE_W-1:0] nlv;
  logic [LVL_W-1:0]        last_lvl;
  logic [LVL_W-1:0]        code_lvl;
  logic [SLOT_W-1:0]       slot_cur;
  logic [SLOT_W-1:0]       slot_inc;
  logic                    emit_ok;
  logic                    finish;

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_level_index   = out_level_index_r;
  assign out_slot_index    = out_slot_index_r;
  assign out_position      = out_position_r;
  assign out_value_missing = out_value_missing_r;
  assign out_error_flag    = out_error_flag_r;
  assign out_last_of_run   = out_last_of_run_r;

  always_comb begin
    if (cfg.level_count == '0) begin
      nlv = LEVEL_CODE_W'(1);
    end else if (cfg.level_count > MAX_LVL_C) begin
      nlv = MAX_LVL_C;
    end else begin
      nlv = cfg.level_count;
    end
  end

  assign last_lvl = LVL_W'(nlv - LEVEL_CODE_W'(1));
  assign code_lvl = LVL_W'(in_level_code - LEVEL_CODE_W'(1));
  // An entry not written since the last clear counts as zero.
  assign slot_cur = valid_r[lvl_r] ? mem_rdata : '0;
  assign slot_inc = (slot_cur == SLOT_MAX) ? slot_cur : slot_cur + SLOT_W'(1);
  assign emit_ok  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt             = state_r;
    kind_nxt              = kind_r;
    lvl_nxt               = lvl_r;
    last_nxt              = last_r;
    pos_nxt               = pos_r;
    valid_nxt             = valid_r;
    mem_re                = 1'b0;
    mem_raddr             = lvl_r;
    mem_we                = 1'b0;
    mem_waddr             = lvl_r;
    mem_wdata             = slot_inc;
    finish                = 1'b0;
    out_valid_nxt         = out_valid_r && out_stall;
    out_level_index_nxt   = out_level_index_r;
    out_slot_index_nxt    = out_slot_index_r;
    out_position_nxt      = out_position_r;
    out_value_missing_nxt = out_value_missing_r;
    out_error_flag_nxt    = out_error_flag_r;
    out_last_of_run_nxt   = out_last_of_run_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (pos_r < MAX_POS_C) begin
            pos_nxt = pos_r + POS_W'(1);
          end
          last_nxt  = in_last_element;
          state_nxt = S_RUN;
          mem_re    = 1'b1;
          if (in_is_missing) begin
            kind_nxt  = cfg.missing_enable ? K_WALK : K_ERROR;
            lvl_nxt   = '0;
            mem_raddr = '0;
          end else if (in_level_code == '0) begin
            kind_nxt = cfg.one_hot_mode ? K_ERROR : K_NONE;
          end else if (in_level_code > nlv) begin
            kind_nxt = K_ERROR;
          end else begin
            kind_nxt  = K_ENTRY;
            lvl_nxt   = code_lvl;
            mem_raddr = code_lvl;
          end
        end
      end
      S_RUN: begin
        case (kind_r)
          K_NONE: begin
            finish = 1'b1;
          end
          K_ERROR: begin
            if (emit_ok) begin
              out_valid_nxt         = 1'b1;
              out_level_index_nxt   = '0;
              out_slot_index_nxt    = '0;
              out_position_nxt      = pos_r;
              out_value_missing_nxt = 1'b0;
              out_error_flag_nxt    = 1'b1;
              out_last_of_run_nxt   = 1'b1;
              finish                = 1'b1;
            end
          end
          K_ENTRY, K_WALK: begin
            if (emit_ok) begin
              out_valid_nxt         = 1'b1;
              out_level_index_nxt   = LEVEL_IDX_W'(lvl_r);
              out_slot_index_nxt    = slot_cur;
              out_position_nxt      = pos_r;
              out_value_missing_nxt = (kind_r == K_WALK);
              out_error_flag_nxt    = 1'b0;
              mem_we                = 1'b1;
              valid_nxt[lvl_r]      = 1'b1;
              if (kind_r == K_WALK && lvl_r != last_lvl) begin
                // Fetch the next level while this one is written back.
                out_last_of_run_nxt = 1'b0;
                lvl_nxt             = lvl_r + LVL_W'(1);
                mem_re              = 1'b1;
                mem_raddr           = lvl_r + LVL_W'(1);
              end else begin
                out_last_of_run_nxt = 1'b1;
                finish              = 1'b1;
              end
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (finish) begin
          state_nxt = S_IDLE;
          if (last_r) begin
            valid_nxt = '0;
            pos_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r              <= kind_nxt;
    lvl_r               <= lvl_nxt;
    last_r              <= last_nxt;
    out_level_index_r   <= out_level_index_nxt;
    out_slot_index_r    <= out_slot_index_nxt;
    out_position_r      <= out_position_nxt;
    out_value_missing_r <= out_value_missing_nxt;
    out_error_flag_r    <= out_error_flag_nxt;
    out_last_of_run_r   <= out_last_of_run_nxt;
  end

endmodule

@@ hw/rtl/sparse_one_hot_scatter_core.sv @@
// Sparse one-hot scatter core.
// Input channel (in_valid / in_stall) carries one category code per vector
// element; an item is taken on an edge with in_valid high and in_stall low.
// Result channel (out_valid / out_stall) returns one item per sparse entry:
// level column, slot within that column, 1-based position and value flag.
// Errors come back as a single item with error_flag set; a reference-level
// code outside one-hot mode returns nothing. last_of_run marks the final
// result of each input item. The cfg_ channel writes level_count (index 0),
// one_hot_mode (1) and missing_enable (2) and is always ready; write only
// while the core is idle.
// Sequence: an ordinary item first reads its level's slot counter from the
// counter RAM, then emits the result and writes the counter back; no new item
// is taken until the result is emitted. A missing item with missing handling
// on walks every configured level, one RAM read-modify-write per level. The
// first result is registered after the counter read.
// Reset and the final element of a vector clear the position counter and all
// slot counters at once through per-level valid flags, so no clearing pass is
// needed. While the receiver stalls, the held result stays put and the walk
// pauses; one new item can still be accepted behind a waiting result.
module sparse_one_hot_scatter_core
  import sosc_pkg::*;
#(
  parameter int MAX_LEVELS = DEF_MAX_LEVELS,
  parameter int MAX_LENGTH = DEF_MAX_LENGTH,
  localparam int POS_W     = $clog2(MAX_LENGTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [LEVEL_CODE_W-1:0] in_level_code,
  input  logic                    in_is_missing,
  input  logic                    in_last_element,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LEVEL_IDX_W-1:0]  out_level_index,
  output logic [SLOT_W-1:0]       out_slot_index,
  output logic [POS_W-1:0]        out_position,
  output logic                    out_value_missing,
  output logic                    out_error_flag,
  output logic                    out_last_of_run,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int LVL_W = $clog2(MAX_LEVELS);

  cfg_t              cfg;
  logic              mem_re;
  logic [LVL_W-1:0]  mem_raddr;
  logic [SLOT_W-1:0] mem_rdata;
  logic              mem_we;
  logic [LVL_W-1:0]  mem_waddr;
  logic [SLOT_W-1:0] mem_wdata;

  // Configuration registers.
  sosc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // One slot counter per level; registered read.
  sosc_slot_ram #(
    .DEPTH  (MAX_LEVELS),
    .ADDR_W (LVL_W)
  ) u_ram (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  // Sequencer: classifies each item, runs the counter read-modify-write
  // and holds the result register towards the receiver.
  sosc_engine #(
    .MAX_LEVELS (MAX_LEVELS),
    .MAX_LENGTH (MAX_LENGTH),
    .POS_W      (POS_W),
    .LVL_W      (LVL_W)
  ) u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_level_code     (in_level_code),
    .in_is_missing     (in_is_missing),
    .in_last_element   (in_last_element),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_level_index   (out_level_index),
    .out_slot_index    (out_slot_index),
    .out_position      (out_position),
    .out_value_missing (out_value_missing),
    .out_error_flag    (out_error_flag),
    .out_last_of_run   (out_last_of_run),
    .mem_re            (mem_re),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata)
  );

endmodule

@@ hw/rtl/sosc_checker.sv @@
`include "sparse_one_hot_scatter_core_assert.svh"

module sosc_checker
  import sosc_pkg::*;
#(
  parameter int POS_W = 21
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [LEVEL_IDX_W-1:0]  out_level_index,
  input logic [SLOT_W-1:0]       out_slot_index,
  input logic [POS_W-1:0]        out_position,
  input logic                    out_value_missing,
  input logic                    out_error_flag,
  input logic                    out_last_of_run
);

  // A waiting result is not withdrawn.
  `SOSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // The core works on one item at a time, so it is busy right after taking one.
  `SOSC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // An error result is a lone item with no entry data.
  `SOSC_ASSERT_IMPL(a_error_shape, out_valid && out_error_flag,
    out_last_of_run && out_level_index == '0 && out_slot_index == '0 && !out_value_missing)

  // Every result belongs to a counted element.
  `SOSC_ASSERT_IMPL(a_position_nonzero, out_valid, out_position != '0)

endmodule

bind sparse_one_hot_scatter_core sosc_checker #(.POS_W(POS_W)) u_sosc_checker (.*);

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sosc_pkg::*;

  // Width of the position port as the core derives it from its default length.
  localparam int POS_W = $clog2(DEF_MAX_LENGTH + 1);
  // Cycles without any handshake before the run is declared hung. The slowest
  // correct stretch is a long random stall on a 64-level missing walk, which
  // stays far below this.
  localparam int IDLE_LIMIT = 2000;
  // An item that returns nothing still passes through the core's run state
  // before the core goes idle, so this covers such an item.
  localparam int DRAIN_CYCLES = 8;

  // One vector element as it goes into the core.
  typedef struct {
    logic [LEVEL_CODE_W-1:0] level_code;
    logic                    is_missing;
    logic                    last_element;
  } element_t;

  // One sparse entry as it comes back.
  typedef struct {
    logic [LEVEL_IDX_W-1:0] level_index;
    logic [SLOT_W-1:0]      slot_index;
    logic [POS_W-1:0]       position;
    logic                   value_missing;
    logic                   error_flag;
    logic                   last_of_run;
  } entry_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [LEVEL_CODE_W-1:0] in_level_code = '0;
  logic                    in_is_missing = 1'b0;
  logic                    in_last_element = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [LEVEL_IDX_W-1:0]  out_level_index;
  logic [SLOT_W-1:0]       out_slot_index;
  logic [POS_W-1:0]        out_position;
  logic                    out_value_missing;
  logic                    out_error_flag;
  logic                    out_last_of_run;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // Elements waiting for the driver, and entries the core still owes us.
  element_t pending_elements[$];
  entry_t   expected_entries[$];

  int elements_queued   = 0;
  int elements_accepted = 0;
  int fail_count        = 0;
  int idle_cycles       = 0;

  // Percentages for the sender going quiet and the receiver stalling.
  int send_gap_pct = 0;
  int stall_pct    = 0;

  // The predictor's own copy of the registers and the counters.
  logic [LEVEL_CODE_W-1:0] model_level_count = RST_LEVEL_COUNT;
  logic                    model_one_hot     = RST_ONE_HOT_MODE;
  logic                    model_missing_en  = RST_MISSING_ENABLE;
  logic [POS_W-1:0]        model_position;
  logic [SLOT_W-1:0]       model_slots [DEF_MAX_LEVELS];

  sparse_one_hot_scatter_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_level_code    (in_level_code),
    .in_is_missing    (in_is_missing),
    .in_last_element  (in_last_element),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_level_index  (out_level_index),
    .out_slot_index   (out_slot_index),
    .out_position     (out_position),
    .out_value_missing(out_value_missing),
    .out_error_flag   (out_error_flag),
    .out_last_of_run  (out_last_of_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A level count of zero behaves as one and anything above the core's level
  // limit behaves as the limit.
  function automatic int live_levels();
    int n;
    n = int'(model_level_count);
    if (n == 0) n = 1;
    if (n > DEF_MAX_LEVELS) n = DEF_MAX_LEVELS;
    return n;
  endfunction

  function automatic void clear_counters();
    model_position = '0;
    foreach (model_slots[i]) model_slots[i] = '0;
  endfunction

  // Hands out a level's next slot number; the counter sticks at its maximum.
  function automatic logic [SLOT_W-1:0] take_slot(logic [LEVEL_IDX_W-1:0] lvl);
    logic [SLOT_W-1:0] s;
    s = model_slots[lvl];
    if (s != SLOT_MAX) model_slots[lvl] = s + SLOT_W'(1);
    return s;
  endfunction

  function automatic void push_entry(logic [LEVEL_IDX_W-1:0] lvl, logic [SLOT_W-1:0] slot,
                                     logic miss, logic err, logic tail);
    entry_t e;
    e.level_index   = lvl;
    e.slot_index    = slot;
    e.position      = model_position;
    e.value_missing = miss;
    e.error_flag    = err;
    e.last_of_run   = tail;
    expected_entries.push_back(e);
  endfunction

  // Works out every entry one accepted element gives, in the order the core
  // must return them, and moves the counters the same way the core does.
  function automatic void predict_entries(element_t el);
    int n;
    logic [LEVEL_IDX_W-1:0] lvl;
    n = live_levels();
    // The position advances up to the length limit, even for elements that give nothing.
    if (model_position < POS_W'(DEF_MAX_LENGTH)) begin
      model_position = model_position + POS_W'(1);
    end
    if (el.is_missing) begin
      // The code of a missing element is ignored altogether.
      if (model_missing_en) begin
        for (int j = 0; j < n; j++) begin
          push_entry(LEVEL_IDX_W'(j), take_slot(LEVEL_IDX_W'(j)), 1'b1, 1'b0,
                     j == n - 1);
        end
      end else begin
        push_entry('0, '0, 1'b0, 1'b1, 1'b1);
      end
    end else if (el.level_code == '0) begin
      // Outside one-hot mode the reference level is dropped silently.
      if (model_one_hot) push_entry('0, '0, 1'b0, 1'b1, 1'b1);
    end else if (int'(el.level_code) > n) begin
      push_entry('0, '0, 1'b0, 1'b1, 1'b1);
    end else begin
      lvl = LEVEL_IDX_W'(el.level_code - LEVEL_CODE_W'(1));
      push_entry(lvl, take_slot(lvl), 1'b0, 1'b0, 1'b1);
    end
    // Counters clear after the final element, whatever it gave.
    if (el.last_element) clear_counters();
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued elements, holding each one while the core stalls.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : element_driver
    element_t el;
    if (!rst_n) begin
      in_valid <= 1'b0;
      clear_counters();
    end else begin
      if (in_valid && !in_stall) begin
        el.level_code   = in_level_code;
        el.is_missing   = in_is_missing;
        el.last_element = in_last_element;
        predict_entries(el);
        elements_accepted++;
      end
      // A new element may only go out once the current one has been taken.
      if (!in_valid || !in_stall) begin
        if (pending_elements.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          el = pending_elements.pop_front();
          in_valid        <= 1'b1;
          in_level_code   <= el.level_code;
          in_is_missing   <= el.is_missing;
          in_last_element <= el.last_element;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each returned entry against the oldest prediction.
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : entry_monitor
    entry_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_entries.size() == 0) begin
          $error("entry returned with none predicted: level_index %0d position %0d",
                 out_level_index, out_position);
          fail_count++;
        end else begin
          want = expected_entries.pop_front();
          check_field("level_index", want.level_index, out_level_index);
          check_field("slot_index", want.slot_index, out_slot_index);
          check_field("position", want.position, out_position);
          check_field("value_missing", want.value_missing, out_value_missing);
          check_field("error_flag", want.error_flag, out_error_flag);
          check_field("last_of_run", want.last_of_run, out_last_of_run);
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any handshake on any channel counts as progress.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  task automatic queue_element(int code, logic miss, logic tail);
    element_t el;
    el.level_code   = LEVEL_CODE_W'(code);
    el.is_missing   = miss;
    el.last_element = tail;
    pending_elements.push_back(el);
    elements_queued++;
  endtask

  // Waits until every queued element has gone in and every predicted entry
  // has come back, then gives the core time to finish an element that
  // returned nothing, so that the registers may be written safely.
  task automatic settle_core();
    do @(posedge clk);
    while (elements_accepted != elements_queued || expected_entries.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back, holding valid high throughout,
  // and updates the predictor's copy on each accepted write.
  task automatic program_cfg(logic [CFG_DATA_W-1:0] levels, logic one_hot, logic miss_en);
    cfg_idx_t               idx [3];
    logic [CFG_DATA_W-1:0]  val [3];
    idx[0] = CFG_LEVEL_COUNT;    val[0] = levels;
    idx[1] = CFG_ONE_HOT_MODE;   val[1] = CFG_DATA_W'(one_hot);
    idx[2] = CFG_MISSING_ENABLE; val[2] = CFG_DATA_W'(miss_en);
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk);
      while (!cfg_ready);
      case (idx[k])
        CFG_LEVEL_COUNT:    model_level_count = val[k];
        CFG_ONE_HOT_MODE:   model_one_hot     = val[k][0];
        CFG_MISSING_ENABLE: model_missing_en  = val[k][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed vectors of random length closed by a final element,
  // with some elements flagged final early to break sequences up.
  task automatic queue_random_vectors(int count);
    int n;
    int len;
    int pick;
    int code;
    logic tail;
    n = live_levels();
    while (count > 0) begin
      len = $urandom_range(1, 12);
      for (int k = 0; k < len && count > 0; k++) begin
        pick = $urandom_range(0, 99);
        code = $urandom_range(0, 64);
        tail = (k == len - 1) || (count == 1) || ($urandom_range(0, 99) < 4);
        if (pick < 12) begin
          queue_element(code, 1'b1, tail);
        end else if (pick < 20) begin
          queue_element(0, 1'b0, tail);
        end else if (pick < 28 && n < DEF_MAX_LEVELS) begin
          queue_element($urandom_range(n + 1, 64), 1'b0, tail);
        end else if (pick < 28) begin
          queue_element(code, 1'b0, tail);
        end else begin
          queue_element($urandom_range(1, n), 1'b0, tail);
        end
        count--;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: two levels, one-hot, missing handling on. Slot counters
    // advance per level, code zero and codes above the count are errors, a
    // missing element spreads over both levels and the final element clears.
    queue_element(1, 1'b0, 1'b0);
    queue_element(2, 1'b0, 1'b0);
    queue_element(1, 1'b0, 1'b0);
    queue_element(0, 1'b0, 1'b0);
    queue_element(3, 1'b0, 1'b0);
    queue_element(64, 1'b0, 1'b0);
    queue_element(64, 1'b1, 1'b0);
    queue_element(2, 1'b0, 1'b1);
    queue_element(2, 1'b0, 1'b0);
    queue_element(0, 1'b1, 1'b1);
    settle_core();

    // Widest setting in reference mode with missing handling off: code zero
    // returns nothing yet still moves the position, even as the final element.
    program_cfg(7'd64, 1'b0, 1'b0);
    queue_element(0, 1'b0, 1'b0);
    queue_element(64, 1'b0, 1'b0);
    queue_element(63, 1'b0, 1'b0);
    queue_element(5, 1'b1, 1'b0);
    queue_element(0, 1'b0, 1'b1);
    queue_element(64, 1'b0, 1'b0);
    queue_element(1, 1'b0, 1'b1);
    settle_core();

    // A level count of zero acts as a single level.
    program_cfg(7'd0, 1'b1, 1'b1);
    queue_element(1, 1'b0, 1'b0);
    queue_element(2, 1'b0, 1'b0);
    queue_element(0, 1'b1, 1'b1);
    settle_core();

    // An oversized level count acts as the full 64, so a missing element
    // produces the longest walk; an error as final element still clears.
    program_cfg(7'd127, 1'b1, 1'b1);
    queue_element(17, 1'b1, 1'b0);
    queue_element(64, 1'b0, 1'b0);
    queue_element(0, 1'b0, 1'b1);
    settle_core();

    // Random phases: each idling pattern is used with two different settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_cfg(7'd64, 1'b1, 1'b1);
        1: program_cfg(7'd1, 1'b0, 1'b1);
        2: program_cfg(7'd5, 1'b1, 1'b0);
        3: program_cfg(7'd64, 1'b0, 1'b1);
        4: program_cfg(7'($urandom_range(2, 63)), 1'b1, 1'b1);
        5: program_cfg(7'd3, 1'b0, 1'b0);
        6: program_cfg(7'($urandom_range(2, 63)), 1'b0, 1'b1);
        default: program_cfg(7'd2, 1'b1, 1'b1);
      endcase
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 78; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 78; end
        default: begin send_gap_pct = 10; stall_pct = 10; end
      endcase
      queue_random_vectors(45);
      settle_core();
    end

    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
